FILE: design/tbf_pkg.sv
// shared types, constants and coefficient register codes for the three-channel biquad filter
package tbf_pkg;

   // channel count and sample width follow the fixed beat layout below
   localparam int CHANNELS    = 3;
   localparam int SAMPLE_BITS = 8;

   // fixed-point format of the filter
   localparam int FRAC_BITS = 14;
   localparam int DATA_BITS = 16;
   localparam int ACC_BITS  = FRAC_BITS + DATA_BITS;
   localparam int PROD_BITS = 2 * DATA_BITS;

   // coefficient register file
   localparam int COEF_COUNT     = 5;
   localparam int CSR_INDEX_BITS = $clog2(COEF_COUNT);

   // coefficient register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_ONE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_TWO = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORWARD_ZERO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORWARD_ONE  = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORWARD_TWO  = CSR_INDEX_BITS'(4);

   // coefficient reset values, Q14
   localparam logic signed [DATA_BITS-1:0] RESET_FEEDBACK_ONE = -16'sd25575;
   localparam logic signed [DATA_BITS-1:0] RESET_FEEDBACK_TWO = 16'sd10508;
   localparam logic signed [DATA_BITS-1:0] RESET_FORWARD_ZERO = 16'sd329;
   localparam logic signed [DATA_BITS-1:0] RESET_FORWARD_ONE  = 16'sd658;
   localparam logic signed [DATA_BITS-1:0] RESET_FORWARD_TWO  = 16'sd329;

   // input beat: one sample set
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_right;
      logic [SAMPLE_BITS-1:0] sample_front;
      logic [SAMPLE_BITS-1:0] sample_left;
   } req_data_type;

   // output beat: one filtered set
   typedef struct packed {
      logic signed [DATA_BITS-1:0] filtered_right;
      logic signed [DATA_BITS-1:0] filtered_front;
      logic signed [DATA_BITS-1:0] filtered_left;
   } rsp_data_type;

   // shared coefficient set
   typedef struct packed {
      logic signed [DATA_BITS-1:0] feedback_one;
      logic signed [DATA_BITS-1:0] feedback_two;
      logic signed [DATA_BITS-1:0] forward_zero;
      logic signed [DATA_BITS-1:0] forward_one;
      logic signed [DATA_BITS-1:0] forward_two;
   } coef_type;

   // lane stage strobes
   typedef struct packed {
      logic load;
      logic advance;
   } lane_ctl_type;

endpackage

FILE: design/tbf_csr.sv
// coefficient register file written through the csr port
module tbf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tbf_pkg::DATA_BITS-1:0]       csr_data,
   output tbf_pkg::coef_type                   coef
);
   import tbf_pkg::*;

   coef_type coef_ff;
   coef_type coef_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // decode the register index, unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FEEDBACK_ONE: coef_in.feedback_one = csr_data;
            CSR_FEEDBACK_TWO: coef_in.feedback_two = csr_data;
            CSR_FORWARD_ZERO: coef_in.forward_zero = csr_data;
            CSR_FORWARD_ONE:  coef_in.forward_one  = csr_data;
            CSR_FORWARD_TWO:  coef_in.forward_two  = csr_data;
            default:          coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.feedback_one <= RESET_FEEDBACK_ONE;
         coef_ff.feedback_two <= RESET_FEEDBACK_TWO;
         coef_ff.forward_zero <= RESET_FORWARD_ZERO;
         coef_ff.forward_one  <= RESET_FORWARD_ONE;
         coef_ff.forward_two  <= RESET_FORWARD_TWO;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

FILE: design/tbf_lane.sv
// one biquad lane: feedback stage, output stage and its two delays
module tbf_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  tbf_pkg::lane_ctl_type               ctl,
   input  tbf_pkg::coef_type                   coef,
   input  logic [tbf_pkg::SAMPLE_BITS-1:0]     sample,
   output logic signed [tbf_pkg::DATA_BITS-1:0] result
);
   import tbf_pkg::*;

   logic signed [DATA_BITS-1:0] d1_ff;
   logic signed [DATA_BITS-1:0] d2_ff;
   logic [ACC_BITS-1:0]         fb_sum_ff;
   logic [ACC_BITS-1:0]         fb_sum_in;
   logic [ACC_BITS-1:0]         ff_sum_ff;
   logic [ACC_BITS-1:0]         ff_sum_in;
   logic signed [DATA_BITS-1:0] result_ff;
   logic [ACC_BITS-1:0]         x_ext;
   logic signed [PROD_BITS-1:0] prod_a1;
   logic signed [PROD_BITS-1:0] prod_a2;
   logic signed [PROD_BITS-1:0] prod_b1;
   logic signed [PROD_BITS-1:0] prod_b2;
   logic signed [PROD_BITS-1:0] prod_b0;
   logic signed [DATA_BITS-1:0] w16;
   logic [ACC_BITS-1:0]         y_sum;

   // first stage: feedback sum and delay half of the output sum
   // only bits below ACC_BITS reach the result, so sums are kept that wide
   assign x_ext   = ACC_BITS'({sample, {FRAC_BITS{1'b0}}});
   assign prod_a1 = PROD_BITS'(coef.feedback_one) * PROD_BITS'(d1_ff);
   assign prod_a2 = PROD_BITS'(coef.feedback_two) * PROD_BITS'(d2_ff);
   assign prod_b1 = PROD_BITS'(coef.forward_one) * PROD_BITS'(d1_ff);
   assign prod_b2 = PROD_BITS'(coef.forward_two) * PROD_BITS'(d2_ff);
   assign fb_sum_in = x_ext - prod_a1[ACC_BITS-1:0] - prod_a2[ACC_BITS-1:0];
   assign ff_sum_in = prod_b1[ACC_BITS-1:0] + prod_b2[ACC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         fb_sum_ff <= fb_sum_in;
         ff_sum_ff <= ff_sum_in;
      end
   end

   // second stage: new intermediate value times forward_zero
   assign w16     = fb_sum_ff[ACC_BITS-1:FRAC_BITS];
   assign prod_b0 = PROD_BITS'(coef.forward_zero) * PROD_BITS'(w16);
   assign y_sum   = prod_b0[ACC_BITS-1:0] + ff_sum_ff;

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         result_ff <= y_sum[ACC_BITS-1:FRAC_BITS];
      end
   end

   // delay line shifts once the output stage completes
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctl.advance) begin
         d2_ff <= d1_ff;
         d1_ff <= w16;
      end
   end

   assign result = result_ff;

endmodule

FILE: design/three_channel_biquad_filter.sv
// top level: lane control, coefficient registers and merge of lane results
//
// Three-channel second-order filter, low-pass with the reset coefficients
// (direct form II, Q14 coefficients shared by all channels). Each req beat
// carries one unsigned sample per channel; each channel runs in its own lane
// with its own two delays, and one rsp beat returns the three 16-bit
// two's-complement results. Each sample set passes a first stage, which
// registers the feedback sum and the delay part of the output sum, and a
// second, which multiplies the new intermediate value by forward_zero,
// registers the result and shifts the delays. The next set is taken once
// the delays have shifted; a finished beat waiting in the output register
// does not hold off the next set. Coefficients are written through the csr
// port, index 0 to 4 in the order feedback_one, feedback_two, forward_zero,
// forward_one, forward_two; other indexes are ignored. Write them only
// while the filter is idle.
module three_channel_biquad_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tbf_pkg::req_data_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tbf_pkg::rsp_data_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tbf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tbf_pkg::DATA_BITS-1:0]      csr_data
);
   import tbf_pkg::*;

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   lane_ctl_type                lane_ctl;
   coef_type                    coef;
   logic [SAMPLE_BITS-1:0]      lane_sample [CHANNELS];
   logic signed [DATA_BITS-1:0] lane_result [CHANNELS];

   // coefficient registers
   tbf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   // stage control: first stage loads on accept, second moves into the output register
   assign req_stall        = s1_valid_ff;
   assign lane_ctl.load    = req_valid && !req_stall;
   assign lane_ctl.advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_valid_in      = lane_ctl.load || (s1_valid_ff && !lane_ctl.advance);
   assign rsp_valid_in     = lane_ctl.advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // split the beat into lanes
   assign lane_sample[0] = req_data.sample_right;
   assign lane_sample[1] = req_data.sample_front;
   assign lane_sample[2] = req_data.sample_left;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      tbf_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .coef   (coef),
         .sample (lane_sample[ch]),
         .result (lane_result[ch])
      );
   end

   // merge lane results into one beat
   assign rsp_data.filtered_right = lane_result[0];
   assign rsp_data.filtered_front = lane_result[1];
   assign rsp_data.filtered_left  = lane_result[2];
   assign rsp_valid               = rsp_valid_ff;

   // no set is taken while the first stage holds one
   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !lane_ctl.load)
      else $error("sample set accepted while first stage occupied");

   // an accepted set occupies the first stage next cycle
   a_load_fills_stage: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.load |=> s1_valid_ff)
      else $error("accepted set lost before first stage");

   // a completed set always shows up at the output
   a_advance_presents: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.advance |=> rsp_valid)
      else $error("completed set not presented on rsp");

   // a blocked output keeps the first stage waiting
   a_backpressure_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("first stage dropped while output stalled");

endmodule

FILE: dv/tb_three_channel_biquad_filter.sv
// self-checking testbench for the three-channel biquad filter
module tb_three_channel_biquad_filter;
   import tbf_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASES         = 7;
   localparam int SETS_PER_PHASE = 136;
   localparam int GAP_MAX        = 8;
   localparam int STYLE_PERIOD   = 64;
   localparam int REQ_BITS       = $bits(req_data_type);

   localparam logic [SAMPLE_BITS-1:0]    SAMPLE_MAX    = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED  = CSR_INDEX_BITS'(COEF_COUNT);
   localparam int                        CSR_INDEX_TOP = (1 << CSR_INDEX_BITS) - 1;

   // notable coefficient values, Q14
   localparam logic [DATA_BITS-1:0] COEF_MOST_NEG = 16'h8000;
   localparam logic [DATA_BITS-1:0] COEF_MOST_POS = 16'h7fff;
   localparam logic [DATA_BITS-1:0] Q14_ONE       = 16'h4000;
   localparam logic [DATA_BITS-1:0] Q14_MINUS_ONE = 16'hc000;
   localparam logic [DATA_BITS-1:0] NOTABLE_COEFS [5] =
      '{16'h0000, COEF_MOST_NEG, COEF_MOST_POS, Q14_ONE, Q14_MINUS_ONE};

   localparam req_data_type NO_SET    = '0;
   localparam rsp_data_type NO_RESULT = '0;

   typedef enum logic {ROW_SET, ROW_COEF} row_kind_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;
   typedef enum logic [2:0] {PLAN_RESET, PLAN_RANDOM, PLAN_EXTREME, PLAN_MIXED, PLAN_FIR}
      coef_plan_type;

   typedef struct packed {
      row_kind_type                kind;
      req_data_type                sample_set;
      logic [CSR_INDEX_BITS-1:0]   index;
      logic [DATA_BITS-1:0]        value;
      logic                        known;
      rsp_data_type                result;
   } stim_row_type;

   // directed stimulus: sample sets and coefficient writes in order
   stim_row_type directed_rows [33] = '{
      // reset coefficients, zero delays: silence stays silent
      '{ROW_SET,  '{8'd0,   8'd0,   8'd0},   '0, '0, 1'b1, '{16'sd0, 16'sd0, 16'sd0}},
      '{ROW_SET,  '{8'd255, 8'd255, 8'd255}, '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd255, 8'd0,   8'd255}, '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd0,   8'd255, 8'd0},   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd170, 8'd85,  8'd15},  '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd128, 8'd127, 8'd1},   '0, '0, 1'b0, NO_RESULT},
      // pass-through: output equals the sample
      '{ROW_COEF, NO_SET, CSR_FEEDBACK_ONE, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FEEDBACK_TWO, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_ZERO, Q14_ONE,  1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_ONE,  16'h0000, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_TWO,  16'h0000, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd255, 8'd0,   8'd128}, '0, '0, 1'b1, '{16'sd255, 16'sd0, 16'sd128}},
      '{ROW_SET,  '{8'd1,   8'd2,   8'd3},   '0, '0, 1'b1, '{16'sd1, 16'sd2, 16'sd3}},
      // inverting pass-through
      '{ROW_COEF, NO_SET, CSR_FORWARD_ZERO, Q14_MINUS_ONE, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd255, 8'd128, 8'd1},   '0, '0, 1'b1, '{-16'sd255, -16'sd128, -16'sd1}},
      // write beyond the register file is dropped
      '{ROW_COEF, NO_SET, CSR_UNMAPPED,     Q14_ONE,       1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd7,   8'd0,   8'd200}, '0, '0, 1'b1, '{-16'sd7, 16'sd0, -16'sd200}},
      // all coefficients at the negative extreme, sums wrap
      '{ROW_COEF, NO_SET, CSR_FEEDBACK_ONE, COEF_MOST_NEG, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FEEDBACK_TWO, COEF_MOST_NEG, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_ZERO, COEF_MOST_NEG, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_ONE,  COEF_MOST_NEG, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_TWO,  COEF_MOST_NEG, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd255, 8'd255, 8'd255}, '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd0,   8'd0,   8'd0},   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd255, 8'd0,   8'd255}, '0, '0, 1'b0, NO_RESULT},
      // all coefficients at the positive extreme
      '{ROW_COEF, NO_SET, CSR_FEEDBACK_ONE, COEF_MOST_POS, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FEEDBACK_TWO, COEF_MOST_POS, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_ZERO, COEF_MOST_POS, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_ONE,  COEF_MOST_POS, 1'b0, NO_RESULT},
      '{ROW_COEF, NO_SET, CSR_FORWARD_TWO,  COEF_MOST_POS, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd255, 8'd255, 8'd255}, '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd0,   8'd255, 8'd0},   '0, '0, 1'b0, NO_RESULT},
      '{ROW_SET,  '{8'd0,   8'd0,   8'd0},   '0, '0, 1'b0, NO_RESULT}
   };

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_data_type              req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_data_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [DATA_BITS-1:0]      csr_data  = '0;

   // filter mirror: coefficients and per-channel delays
   coef_type                    coefs;
   logic signed [DATA_BITS-1:0] delay_near [CHANNELS];
   logic signed [DATA_BITS-1:0] delay_far  [CHANNELS];
   rsp_data_type                pending_filtered [$];
   rsp_data_type                oldest_filtered;

   int              fail_count  = 0;
   int              burst_left  = 0;
   int              cycle_count = 0;
   stall_style_type stall_style = STALL_NONE;

   three_channel_biquad_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // mirror a coefficient write, unmapped indexes are dropped
   function automatic void store_coef(input logic [CSR_INDEX_BITS-1:0] index,
                                      input logic [DATA_BITS-1:0] value);
      case (index)
         CSR_FEEDBACK_ONE: coefs.feedback_one = value;
         CSR_FEEDBACK_TWO: coefs.feedback_two = value;
         CSR_FORWARD_ZERO: coefs.forward_zero = value;
         CSR_FORWARD_ONE:  coefs.forward_one  = value;
         CSR_FORWARD_TWO:  coefs.forward_two  = value;
         default: ;
      endcase
   endfunction

   // one direct-form-II step on every channel, 32-bit wrapping sums
   function automatic rsp_data_type run_biquads(input req_data_type sample_set);
      logic        [SAMPLE_BITS-1:0] samples [CHANNELS];
      logic signed [DATA_BITS-1:0]   results [CHANNELS];
      logic signed [31:0]            a1, a2, b0, b1, b2, x, d1, d2, w, mid, y;
      logic signed [DATA_BITS-1:0]   w16;
      rsp_data_type                  filtered;
      samples[0] = sample_set.sample_right;
      samples[1] = sample_set.sample_front;
      samples[2] = sample_set.sample_left;
      a1 = 32'(coefs.feedback_one);
      a2 = 32'(coefs.feedback_two);
      b0 = 32'(coefs.forward_zero);
      b1 = 32'(coefs.forward_one);
      b2 = 32'(coefs.forward_two);
      for (int c = 0; c < CHANNELS; c++) begin
         x   = 32'(samples[c]) << FRAC_BITS;
         d1  = 32'(delay_near[c]);
         d2  = 32'(delay_far[c]);
         w   = x - a1 * d1 - a2 * d2;
         w16 = w[FRAC_BITS +: DATA_BITS];
         mid = 32'(w16);
         y   = b0 * mid + b1 * d1 + b2 * d2;
         results[c]    = y[FRAC_BITS +: DATA_BITS];
         delay_far[c]  = delay_near[c];
         delay_near[c] = w16;
      end
      filtered.filtered_right = results[0];
      filtered.filtered_front = results[1];
      filtered.filtered_left  = results[2];
      return filtered;
   endfunction

   // offer one sample set in bursts with random gaps between them
   task automatic send_set(input req_data_type sample_set, input logic known,
                           input rsp_data_type typed_result);
      rsp_data_type predicted;
      if (burst_left == 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_data  <= sample_set;
      do @(posedge clock); while (req_stall);
      predicted = run_biquads(sample_set);
      pending_filtered.push_back(known ? typed_result : predicted);
      burst_left--;
   endtask

   // drop valid and wait until every filtered beat is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_filtered.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      store_coef(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic signed [DATA_BITS-1:0] want,
                                       input logic signed [DATA_BITS-1:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // receiver stall pattern in one of four styles, picked at random and changed periodically
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % STYLE_PERIOD == 0)
         stall_style <= stall_style_type'($urandom_range(0, 3));
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= cycle_count[2];
      endcase
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // compare each accepted filtered beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_filtered.size() == 0) begin
            $error("filtered beat with no sample set outstanding");
            fail_count++;
         end else begin
            oldest_filtered = pending_filtered.pop_front();
            check_field("filtered_right", oldest_filtered.filtered_right, rsp_data.filtered_right);
            check_field("filtered_front", oldest_filtered.filtered_front, rsp_data.filtered_front);
            check_field("filtered_left",  oldest_filtered.filtered_left,  rsp_data.filtered_left);
         end
      end
   end

   initial begin
      req_data_type         sample_set;
      logic [DATA_BITS-1:0] coef_values [COEF_COUNT];
      coef_plan_type        plan;
      int                   style;
      coefs = '{RESET_FEEDBACK_ONE, RESET_FEEDBACK_TWO, RESET_FORWARD_ZERO,
                RESET_FORWARD_ONE, RESET_FORWARD_TWO};
      foreach (delay_near[c]) begin
         delay_near[c] = '0;
         delay_far[c]  = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_COEF) begin
            wait_idle();
            csr_write(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_set(directed_rows[r].sample_set, directed_rows[r].known,
                     directed_rows[r].result);
         end
      end

      // random phases, each starting with a fresh write of a coefficient set
      sample_set = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         plan = coef_plan_type'(phase % 5);
         foreach (coef_values[i]) begin
            case (plan)
               PLAN_RANDOM:  coef_values[i] = 16'($urandom);
               PLAN_EXTREME: coef_values[i] = $urandom_range(0, 1) ? COEF_MOST_POS
                                                                    : COEF_MOST_NEG;
               PLAN_MIXED:   coef_values[i] = NOTABLE_COEFS[$urandom_range(0, 4)];
               PLAN_FIR:     coef_values[i] = (i <= CSR_FEEDBACK_TWO) ? '0 : 16'($urandom);
               default:      ;
            endcase
         end
         if (plan == PLAN_RESET)
            coef_values = '{RESET_FEEDBACK_ONE, RESET_FEEDBACK_TWO, RESET_FORWARD_ZERO,
                            RESET_FORWARD_ONE, RESET_FORWARD_TWO};
         wait_idle();
         foreach (coef_values[i])
            csr_write(CSR_INDEX_BITS'(i), coef_values[i]);
         csr_write(CSR_INDEX_BITS'($urandom_range(COEF_COUNT, CSR_INDEX_TOP)), 16'($urandom));

         // mostly random sets, some rail-to-rail, some held for a step response
         for (int n = 0; n < SETS_PER_PHASE; n++) begin
            style = $urandom_range(0, 9);
            if (style < 6) begin
               sample_set = req_data_type'(REQ_BITS'($urandom));
            end else if (style < 8) begin
               sample_set.sample_right = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
               sample_set.sample_front = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
               sample_set.sample_left  = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
            end
            send_set(sample_set, 1'b0, NO_RESULT);
         end
      end

      // drain and make sure nothing extra comes out
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_filtered.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
